/* design/fttq_pkg.sv */
// Package: constants, codes and controller/datapath interface types for the timer queues.
package fttq_pkg;

   localparam int NUM_TIMERS = 32;
   localparam int NUM_QUEUES = 5;
   localparam int ID_W       = $clog2(NUM_TIMERS);
   localparam int QIDX_W     = $clog2(NUM_QUEUES);
   localparam int CNT_W      = $clog2(NUM_TIMERS + 1);
   localparam int TIME_W     = 48;
   localparam int TO_W       = 32;
   localparam int WAIT_W     = 31;
   localparam int NUM_CSR    = 4;
   localparam int CSR_IDX_W  = 2;

   typedef enum logic [1:0] {
      FUNC_ATTACH = 2'd0,
      FUNC_CHECK  = 2'd1,
      FUNC_XFER   = 2'd2,
      FUNC_WAIT   = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      KIND_EXPIRED = 2'd0,
      KIND_COUNT   = 2'd1,
      KIND_WAIT    = 2'd2,
      KIND_ACK     = 2'd3
   } kind_type;

   // which queue the head/tail registers are looked up at
   typedef enum logic [1:0] {
      QS_MEMBER = 2'd0,
      QS_TARGET = 2'd1,
      QS_SRC    = 2'd2,
      QS_SCAN   = 2'd3
   } qsrc_type;

   typedef struct packed {
      logic     load;
      logic     set_cur_head;
      logic     exp_write;
      logic     unlink_do;
      logic     link_do;
      qsrc_type qsrc;
      logic     scan_inc;
      logic     w_update;
      logic     out_load;
      logic     out_final;
      logic     cnt_inc;
   } cmd_type;

   typedef struct packed {
      func_type func;
      logic     head_vld;
      logic     late;
      logic     scan_last;
      logic     scan_zero;
      logic     out_free;
      logic     att_ok;
      logic     xfr_ok;
   } stat_type;

endpackage

/* design/fttq_ram.sv */
// Generic single write port RAM with registered read.
module fttq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/fttq_ctrl.sv */
// Controller: sequences attach, check, transfer and wait query over the datapath.
module fttq_ctrl
   import fttq_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  logic [1:0] req_func,
   input  stat_type stat,
   output cmd_type  cmd
);

   typedef enum logic [10:0] {
      ST_IDLE     = 11'b00000000001,
      ST_CHK_HEAD = 11'b00000000010,
      ST_XFR_HEAD = 11'b00000000100,
      ST_U_RD     = 11'b00000001000,
      ST_U_WR     = 11'b00000010000,
      ST_A_LINK   = 11'b00000100000,
      ST_EMIT_EXP = 11'b00001000000,
      ST_WAIT_HD  = 11'b00010000000,
      ST_WAIT_RD  = 11'b00100000000,
      ST_WAIT_CMP = 11'b01000000000,
      ST_EMIT_FIN = 11'b10000000000
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      cmd.qsrc  = QS_SCAN;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               case (func_type'(req_func))
                  FUNC_ATTACH: state_in = stat.att_ok ? ST_U_RD : ST_EMIT_FIN;
                  FUNC_CHECK:  state_in = ST_CHK_HEAD;
                  FUNC_XFER:   state_in = stat.xfr_ok ? ST_XFR_HEAD : ST_EMIT_FIN;
                  default:     state_in = ST_WAIT_HD;
               endcase
            end
         end
         ST_CHK_HEAD: begin
            cmd.qsrc = QS_SCAN;
            if (stat.head_vld) begin
               cmd.set_cur_head = 1'b1;
               state_in = ST_U_RD;
            end else if (stat.scan_last) begin
               state_in = ST_EMIT_FIN;
            end else begin
               cmd.scan_inc = 1'b1;
            end
         end
         ST_XFR_HEAD: begin
            cmd.qsrc = QS_SRC;
            if (stat.head_vld) begin
               cmd.set_cur_head = 1'b1;
               state_in = ST_U_RD;
            end else begin
               state_in = ST_EMIT_FIN;
            end
         end
         ST_U_RD: begin
            cmd.exp_write = (stat.func != FUNC_CHECK);
            state_in = ST_U_WR;
         end
         ST_U_WR: begin
            cmd.qsrc = QS_MEMBER;
            if (stat.func == FUNC_CHECK) begin
               if (!stat.scan_zero && stat.late) begin
                  if (stat.scan_last) begin
                     state_in = ST_EMIT_FIN;
                  end else begin
                     cmd.scan_inc = 1'b1;
                     state_in = ST_CHK_HEAD;
                  end
               end else begin
                  cmd.unlink_do = 1'b1;
                  state_in = ST_EMIT_EXP;
               end
            end else begin
               cmd.unlink_do = 1'b1;
               state_in = ST_A_LINK;
            end
         end
         ST_A_LINK: begin
            cmd.qsrc    = QS_TARGET;
            cmd.link_do = 1'b1;
            state_in = (stat.func == FUNC_ATTACH) ? ST_EMIT_FIN : ST_XFR_HEAD;
         end
         ST_EMIT_EXP: begin
            if (stat.out_free) begin
               cmd.out_load = 1'b1;
               cmd.cnt_inc  = 1'b1;
               state_in = ST_CHK_HEAD;
            end
         end
         ST_WAIT_HD: begin
            cmd.qsrc = QS_SCAN;
            if (stat.head_vld) begin
               cmd.set_cur_head = 1'b1;
               state_in = ST_WAIT_RD;
            end else if (stat.scan_last) begin
               state_in = ST_EMIT_FIN;
            end else begin
               cmd.scan_inc = 1'b1;
            end
         end
         ST_WAIT_RD: begin
            state_in = ST_WAIT_CMP;
         end
         ST_WAIT_CMP: begin
            cmd.w_update = 1'b1;
            if (stat.scan_last) begin
               state_in = ST_EMIT_FIN;
            end else begin
               cmd.scan_inc = 1'b1;
               state_in = ST_WAIT_HD;
            end
         end
         ST_EMIT_FIN: begin
            if (stat.out_free) begin
               cmd.out_load  = 1'b1;
               cmd.out_final = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

/* design/fttq_dpath.sv */
// Datapath: timeout registers, queue heads/tails, link and expiry RAMs, result register.
module fttq_dpath
   import fttq_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  cmd_type              cmd,
   output stat_type             stat,
   input  logic [1:0]           req_func,
   input  logic [4:0]           req_timer_id,
   input  logic [2:0]           req_queue_sel,
   input  logic [2:0]           req_dest_queue,
   input  logic [47:0]          req_now_ms,
   input  logic [30:0]          req_max_wait,
   input  logic                 csr_wen,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [TO_W-1:0]      csr_wdata,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [1:0]           rsp_kind,
   output logic [4:0]           rsp_expired_id,
   output logic [30:0]          rsp_value,
   output logic                 rsp_last
);

   logic [TO_W-1:0]       timeout_ff [NUM_CSR];
   func_type              func_ff;
   logic [QIDX_W-1:0]     src_ff, tq_ff, scan_ff;
   logic [TIME_W-1:0]     now_ff;
   logic [WAIT_W-1:0]     w_ff;
   logic [ID_W-1:0]       cur_id_ff;
   logic [CNT_W-1:0]      cnt_ff;
   logic [NUM_QUEUES-1:0] head_vld_ff, tail_vld_ff;
   logic [ID_W-1:0]       head_id_ff [NUM_QUEUES];
   logic [ID_W-1:0]       tail_id_ff [NUM_QUEUES];
   logic [NUM_TIMERS-1:0] queued_ff, exp_vld_ff;
   logic [QIDX_W-1:0]     member_ff [NUM_TIMERS];
   logic                  exp_vld_rd_ff;
   logic                  rsp_valid_ff, rsp_last_ff;
   kind_type              rsp_kind_ff;
   logic [4:0]            rsp_id_ff;
   logic [30:0]           rsp_value_ff;

   logic [QIDX_W-1:0] qaddr;
   logic              hv, tv, hit_h, hit_t, uq;
   logic [ID_W-1:0]   hid, tid;
   logic [TO_W-1:0]   to_sel;
   logic [TIME_W:0]   exp_sum;
   logic [TIME_W-1:0] exp_new, exp_rd, exp_eff, gap;
   logic              exp_we, late;
   logic [ID_W-1:0]   next_rd, prev_rd;
   logic              nxt_we, prv_we;
   logic [ID_W-1:0]   nxt_addr, nxt_data, prv_addr, prv_data;
   logic              out_free;

   always_comb begin
      case (cmd.qsrc)
         QS_MEMBER: qaddr = member_ff[cur_id_ff];
         QS_TARGET: qaddr = tq_ff;
         QS_SRC:    qaddr = src_ff;
         default:   qaddr = scan_ff;
      endcase
   end

   assign hv    = head_vld_ff[qaddr];
   assign tv    = tail_vld_ff[qaddr];
   assign hid   = head_id_ff[qaddr];
   assign tid   = tail_id_ff[qaddr];
   assign hit_h = hv && (hid == cur_id_ff);
   assign hit_t = tv && (tid == cur_id_ff);
   assign uq    = cmd.unlink_do && queued_ff[cur_id_ff];

   always_comb begin
      to_sel = '0;
      if (tq_ff >= QIDX_W'(1) && 32'(tq_ff) <= 32'(NUM_CSR)) begin
         to_sel = timeout_ff[CSR_IDX_W'(tq_ff - QIDX_W'(1))];
      end
   end

   // now + timeout, saturating
   assign exp_sum = {1'b0, now_ff} + (TIME_W + 1)'(to_sel);
   assign exp_new = exp_sum[TIME_W] ? '1 : exp_sum[TIME_W-1:0];
   assign exp_we  = cmd.exp_write && (to_sel != '0);
   assign exp_eff = exp_vld_rd_ff ? exp_rd : '0;
   assign late    = exp_eff > now_ff;
   assign gap     = late ? (exp_eff - now_ff) : '0;

   fttq_ram #(.WIDTH(TIME_W), .DEPTH(NUM_TIMERS)) u_exp_ram (
      .clock   (clock),
      .wr_en   (exp_we),
      .wr_addr (cur_id_ff),
      .wr_data (exp_new),
      .rd_addr (cur_id_ff),
      .rd_data (exp_rd)
   );

   always_comb begin
      nxt_we   = 1'b0;
      nxt_addr = prev_rd;
      nxt_data = next_rd;
      prv_we   = 1'b0;
      prv_addr = next_rd;
      prv_data = prev_rd;
      if (uq && !hit_h && !hit_t) begin
         nxt_we = 1'b1;
         prv_we = 1'b1;
      end
      if (cmd.link_do && hv) begin
         nxt_we   = 1'b1;
         nxt_addr = tid;
         nxt_data = cur_id_ff;
         prv_we   = 1'b1;
         prv_addr = cur_id_ff;
         prv_data = tid;
      end
   end

   fttq_ram #(.WIDTH(ID_W), .DEPTH(NUM_TIMERS)) u_next_ram (
      .clock   (clock),
      .wr_en   (nxt_we),
      .wr_addr (nxt_addr),
      .wr_data (nxt_data),
      .rd_addr (cur_id_ff),
      .rd_data (next_rd)
   );

   fttq_ram #(.WIDTH(ID_W), .DEPTH(NUM_TIMERS)) u_prev_ram (
      .clock   (clock),
      .wr_en   (prv_we),
      .wr_addr (prv_addr),
      .wr_data (prv_data),
      .rd_addr (cur_id_ff),
      .rd_data (prev_rd)
   );

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         head_vld_ff  <= '0;
         tail_vld_ff  <= '0;
         queued_ff    <= '0;
         exp_vld_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_CSR; i++) begin
            timeout_ff[i] <= '0;
         end
      end else begin
         if (csr_wen) begin
            timeout_ff[csr_index] <= csr_wdata;
         end
         if (exp_we) begin
            exp_vld_ff[cur_id_ff] <= 1'b1;
         end
         if (uq) begin
            queued_ff[cur_id_ff] <= 1'b0;
            if (hit_h && hit_t) begin
               head_vld_ff[qaddr] <= 1'b0;
               tail_vld_ff[qaddr] <= 1'b0;
            end
         end
         if (cmd.link_do) begin
            head_vld_ff[qaddr]   <= 1'b1;
            tail_vld_ff[qaddr]   <= 1'b1;
            queued_ff[cur_id_ff] <= 1'b1;
         end
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      exp_vld_rd_ff <= exp_vld_ff[cur_id_ff];
      if (cmd.load) begin
         func_ff   <= func_type'(req_func);
         src_ff    <= QIDX_W'(req_queue_sel);
         tq_ff     <= (func_type'(req_func) == FUNC_XFER) ? QIDX_W'(req_dest_queue)
                                                         : QIDX_W'(req_queue_sel);
         now_ff    <= req_now_ms;
         w_ff      <= req_max_wait;
         cur_id_ff <= ID_W'(req_timer_id);
         scan_ff   <= (func_type'(req_func) == FUNC_WAIT) ? QIDX_W'(1) : '0;
         cnt_ff    <= '0;
      end
      if (cmd.set_cur_head) begin
         cur_id_ff <= hid;
      end
      if (cmd.scan_inc) begin
         scan_ff <= scan_ff + QIDX_W'(1);
      end
      if (cmd.cnt_inc) begin
         cnt_ff <= cnt_ff + CNT_W'(1);
      end
      if (cmd.w_update && (gap < TIME_W'(w_ff))) begin
         w_ff <= gap[WAIT_W-1:0];
      end
      if (uq && !(hit_h && hit_t)) begin
         if (hit_h) begin
            head_id_ff[qaddr] <= next_rd;
         end else if (hit_t) begin
            tail_id_ff[qaddr] <= prev_rd;
         end
      end
      if (cmd.link_do) begin
         if (!hv) begin
            head_id_ff[qaddr] <= cur_id_ff;
         end
         tail_id_ff[qaddr]    <= cur_id_ff;
         member_ff[cur_id_ff] <= qaddr;
      end
      if (cmd.out_load) begin
         if (cmd.out_final) begin
            rsp_id_ff   <= '0;
            rsp_last_ff <= 1'b1;
            case (func_ff)
               FUNC_CHECK: begin
                  rsp_kind_ff  <= KIND_COUNT;
                  rsp_value_ff <= 31'(cnt_ff);
               end
               FUNC_WAIT: begin
                  rsp_kind_ff  <= KIND_WAIT;
                  rsp_value_ff <= w_ff;
               end
               default: begin
                  rsp_kind_ff  <= KIND_ACK;
                  rsp_value_ff <= '0;
               end
            endcase
         end else begin
            rsp_kind_ff  <= KIND_EXPIRED;
            rsp_id_ff    <= 5'(cur_id_ff);
            rsp_value_ff <= '0;
            rsp_last_ff  <= 1'b0;
         end
      end
   end

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      stat.func      = func_ff;
      stat.head_vld  = hv;
      stat.late      = late;
      stat.scan_last = (scan_ff == QIDX_W'(NUM_QUEUES - 1));
      stat.scan_zero = (scan_ff == '0);
      stat.out_free  = out_free;
      stat.att_ok    = ({27'd0, req_timer_id} < 32'(NUM_TIMERS))
                       && ({29'd0, req_queue_sel} < 32'(NUM_QUEUES));
      stat.xfr_ok    = ({29'd0, req_queue_sel} < 32'(NUM_QUEUES))
                       && ({29'd0, req_dest_queue} < 32'(NUM_QUEUES))
                       && (req_queue_sel != req_dest_queue);
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_kind       = rsp_kind_ff;
   assign rsp_expired_id = rsp_id_ff;
   assign rsp_value      = rsp_value_ff;
   assign rsp_last       = rsp_last_ff;

   a_head_tail_pair: assert property (@(posedge clock) disable iff (reset)
      head_vld_ff == tail_vld_ff)
      else $error("queue head and tail disagree on emptiness");

   a_no_unlink_link: assert property (@(posedge clock) disable iff (reset)
      !(cmd.unlink_do && cmd.link_do))
      else $error("unlink and link in one cycle");

   a_out_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> out_free)
      else $error("result register overwritten");

   a_link_sets: assert property (@(posedge clock) disable iff (reset)
      cmd.link_do |=> queued_ff[$past(cur_id_ff)])
      else $error("linked id not marked queued");

endmodule

/* design/fixed_timeout_timer_queues_unit.sv */
// Timer queues: 32 timer ids in five linked FIFO queues (queue 0 pending, 1 to 4 with
// programmable timeouts). One item is worked at a time: attach unlinks and relinks one
// timer; wait query reads the head of each occupied queue 1 to 4; check removes every timer
// of queue 0 and the due heads of queues 1 to 4; transfer moves the source queue entry by
// entry; an attach or transfer naming a bad queue goes straight to its final result. The
// link and expiry RAMs, each with one write port and a registered read, are walked one
// entry per step, and every result held back by rsp_ready adds its wait. The result register
// lets a new item be accepted while the final result is still waiting.
module fixed_timeout_timer_queues_unit
   import fttq_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_func,
   input  logic [4:0]  req_timer_id,
   input  logic [2:0]  req_queue_sel,
   input  logic [2:0]  req_dest_queue,
   input  logic [47:0] req_now_ms,
   input  logic [30:0] req_max_wait,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_kind,
   output logic [4:0]  rsp_expired_id,
   output logic [30:0] rsp_value,
   output logic        rsp_last,
   input  logic        csr_wen,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   cmd_type  cmd;
   stat_type stat;

   fttq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_func  (req_func),
      .stat      (stat),
      .cmd       (cmd)
   );

   fttq_dpath u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .req_func       (req_func),
      .req_timer_id   (req_timer_id),
      .req_queue_sel  (req_queue_sel),
      .req_dest_queue (req_dest_queue),
      .req_now_ms     (req_now_ms),
      .req_max_wait   (req_max_wait),
      .csr_wen        (csr_wen),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_kind       (rsp_kind),
      .rsp_expired_id (rsp_expired_id),
      .rsp_value      (rsp_value),
      .rsp_last       (rsp_last)
   );

endmodule

/* test/tb_fixed_timeout_timer_queues_unit.sv */
// Testbench for the timer queues unit: directed and random items checked against a local predictor.
`timescale 1ns / 1ps
module tb_fixed_timeout_timer_queues_unit
   import fttq_pkg::*;
();

   localparam logic [5:0]  EMPTY = 6'd63;
   localparam logic [47:0] TMAX  = 48'hFFFF_FFFF_FFFF;

   typedef struct packed {
      logic [1:0]  kind;
      logic [4:0]  id;
      logic [30:0] value;
      logic        last;
   } rsp_type;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_ready;
   logic [1:0]  req_func = '0;
   logic [4:0]  req_timer_id = '0;
   logic [2:0]  req_queue_sel = '0;
   logic [2:0]  req_dest_queue = '0;
   logic [47:0] req_now_ms = '0;
   logic [30:0] req_max_wait = '0;
   logic        rsp_valid;
   logic        rsp_ready = 0;
   logic [1:0]  rsp_kind;
   logic [4:0]  rsp_expired_id;
   logic [30:0] rsp_value;
   logic        rsp_last;
   logic        csr_wen = 0;
   logic [1:0]  csr_index = '0;
   logic [31:0] csr_wdata = '0;

   fixed_timeout_timer_queues_unit dut (.*);

   always #1 clock = ~clock;

   // predictor state
   logic [31:0] tmo [4];
   logic [47:0] exp_t [32];
   logic [2:0]  memb [32];
   logic        queued [32];
   logic [5:0]  nxt [32];
   logic [5:0]  prv [32];
   logic [5:0]  head [5];
   logic [5:0]  tail [5];

   rsp_type     pending_rsp [$];
   int          errors = 0;
   int          send_idle = 16;
   int          recv_idle = 62;
   logic [47:0] clk_ms = 0;

   function automatic logic [47:0] q_timeout(int q);
      return (q >= 1 && q <= 4) ? 48'(tmo[q-1]) : 48'd0;
   endfunction

   function automatic void unlink(int id);
      int q;
      if (!queued[id]) return;
      q = memb[id];
      if (head[q] == id && tail[q] == id) begin
         head[q] = EMPTY; tail[q] = EMPTY;
      end else if (head[q] == id) begin
         head[q] = nxt[id];
      end else if (tail[q] == id) begin
         tail[q] = prv[id];
      end else begin
         nxt[prv[id]] = nxt[id];
         prv[nxt[id]] = prv[id];
      end
      queued[id] = 0;
   endfunction

   function automatic void attach(int id, int q, logic [47:0] now);
      logic [47:0] t;
      t = q_timeout(q);
      if (t > 0) exp_t[id] = (now > TMAX - t) ? TMAX : now + t;
      unlink(id);
      if (head[q] == EMPTY) head[q] = 6'(id);
      else begin
         nxt[tail[q]] = 6'(id);
         prv[id] = tail[q];
      end
      tail[q] = 6'(id);
      memb[id] = 3'(q);
      queued[id] = 1;
   endfunction

   function automatic void push(kind_type k, int id, logic [47:0] v, logic l);
      rsp_type r;
      r.kind = k; r.id = 5'(id); r.value = v[30:0]; r.last = l;
      pending_rsp.push_back(r);
   endfunction

   function automatic void predict_item(logic [1:0] f, int tid, int qs, int dq,
                                        logic [47:0] now, logic [30:0] mw);
      int n, id;
      logic [47:0] w, d;
      n = 0;
      case (f)
         FUNC_ATTACH: begin
            if (qs < NUM_QUEUES) attach(tid, qs, now);
            push(KIND_ACK, 0, 0, 1);
         end
         FUNC_CHECK: begin
            while (head[0] != EMPTY) begin
               id = head[0]; unlink(id); push(KIND_EXPIRED, id, 0, 0); n++;
            end
            for (int q = 1; q < NUM_QUEUES; q++)
               while (head[q] != EMPTY && exp_t[head[q]] <= now) begin
                  id = head[q]; unlink(id); push(KIND_EXPIRED, id, 0, 0); n++;
               end
            push(KIND_COUNT, 0, n, 1);
         end
         FUNC_XFER: begin
            if (qs < NUM_QUEUES && dq < NUM_QUEUES && qs != dq)
               while (head[qs] != EMPTY) attach(head[qs], dq, now);
            push(KIND_ACK, 0, 0, 1);
         end
         default: begin
            w = 48'(mw);
            for (int q = 1; q < NUM_QUEUES; q++)
               if (head[q] != EMPTY) begin
                  d = (exp_t[head[q]] > now) ? exp_t[head[q]] - now : 0;
                  if (d < w) w = d;
               end
            push(KIND_WAIT, 0, w, 1);
         end
      endcase
   endfunction

   task automatic send_item(logic [1:0] f, int tid, int qs, int dq,
                            logic [47:0] now, logic [30:0] mw);
      if ($urandom_range(99) < send_idle) begin
         req_valid <= 0;
         do @(posedge clock); while ($urandom_range(99) < send_idle);
      end
      req_valid <= 1; req_func <= f; req_timer_id <= 5'(tid);
      req_queue_sel <= 3'(qs); req_dest_queue <= 3'(dq);
      req_now_ms <= now; req_max_wait <= mw;
      predict_item(f, tid, qs, dq, now, mw);
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic drain();
      req_valid <= 0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (150) @(posedge clock);
   endtask

   task automatic write_csr(int idx, logic [31:0] v);
      csr_wen <= 1; csr_index <= 2'(idx); csr_wdata <= v;
      tmo[idx] = v;
      @(posedge clock);
      csr_wen <= 0;
      @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (!reset) rsp_ready <= ($urandom_range(99) >= recv_idle);
      if (!reset && rsp_valid && rsp_ready) begin
         rsp_type e;
         if (pending_rsp.size() == 0) begin
            $error("unexpected result kind %0d", rsp_kind); errors++;
         end else begin
            e = pending_rsp.pop_front();
            if (rsp_kind !== e.kind) begin
               $error("kind exp %0d got %0d", e.kind, rsp_kind); errors++;
            end
            if (rsp_expired_id !== e.id) begin
               $error("expired_id exp %0d got %0d", e.id, rsp_expired_id); errors++;
            end
            if (rsp_value !== e.value) begin
               $error("value exp %0d got %0d", e.value, rsp_value); errors++;
            end
            if (rsp_last !== e.last) begin
               $error("last exp %0d got %0d", e.last, rsp_last); errors++;
            end
         end
      end
   end

   task automatic test_directed();
      write_csr(0, 32'd10); write_csr(1, 32'hFFFF_FFFF);
      write_csr(2, 32'd0);  write_csr(3, 32'd1);
      send_item(FUNC_WAIT, 0, 0, 0, 0, 31'h7FFF_FFFF);
      send_item(FUNC_ATTACH, 0, 0, 0, 0, 0);
      send_item(FUNC_ATTACH, 31, 1, 0, 5, 0);
      send_item(FUNC_ATTACH, 5, 2, 0, TMAX - 3, 0);
      send_item(FUNC_ATTACH, 6, 3, 0, 7, 0);
      send_item(FUNC_ATTACH, 7, 4, 0, 7, 0);
      send_item(FUNC_ATTACH, 8, 1, 0, 7, 0);
      send_item(FUNC_ATTACH, 31, 1, 0, 8, 0);
      send_item(FUNC_ATTACH, 9, 7, 0, 8, 0);
      send_item(FUNC_XFER, 0, 3, 3, 8, 0);
      send_item(FUNC_XFER, 0, 6, 1, 8, 0);
      send_item(FUNC_WAIT, 0, 0, 0, 8, 31'd3);
      send_item(FUNC_WAIT, 0, 0, 0, 8, 31'h7FFF_FFFF);
      send_item(FUNC_XFER, 0, 4, 1, 9, 0);
      send_item(FUNC_CHECK, 0, 0, 0, 9, 0);
      send_item(FUNC_CHECK, 0, 0, 0, 20, 0);
      send_item(FUNC_XFER, 0, 2, 0, 20, 0);
      send_item(FUNC_CHECK, 0, 7, 7, TMAX, 31'h7FFF_FFFF);
      clk_ms = 20;
      drain();
   endtask

   task automatic run_random(int count);
      int r, f;
      for (int i = 0; i < count; i++) begin
         clk_ms += $urandom_range(30);
         if ($urandom_range(49) == 0) clk_ms = clk_ms + {$urandom, 16'h0};
         if (clk_ms > TMAX - 48'h1_0000_0000) clk_ms = 0;
         r = $urandom_range(99);
         f = (r < 55) ? FUNC_ATTACH : (r < 70) ? FUNC_CHECK : (r < 85) ? FUNC_XFER
             : FUNC_WAIT;
         send_item(2'(f), $urandom_range(31),
                   ($urandom_range(9) == 0) ? $urandom_range(7) : $urandom_range(4),
                   ($urandom_range(9) == 0) ? $urandom_range(7) : $urandom_range(4),
                   clk_ms, 31'($urandom));
         if (i == count / 2) begin
            req_valid <= 0;
            do @(posedge clock); while (pending_rsp.size() != 0);
         end
      end
      drain();
   endtask

   task automatic test_random_phases();
      write_csr(0, 32'd5); write_csr(1, 32'd40); write_csr(2, 32'd0); write_csr(3, 32'd100);
      run_random(38);
      send_idle = 62; recv_idle = 16;
      write_csr(0, 32'd0); write_csr(1, 32'd1); write_csr(2, 32'd25); write_csr(3, 32'hFFFF_FFFF);
      run_random(38);
      send_idle = 0; recv_idle = 0;
      write_csr(0, 32'd3); write_csr(1, 32'd12); write_csr(2, $urandom); write_csr(3, 32'd0);
      run_random(38);
   endtask

   initial begin
      for (int i = 0; i < 4; i++) tmo[i] = 0;
      for (int i = 0; i < 32; i++) begin
         exp_t[i] = 0; memb[i] = 0; queued[i] = 0; nxt[i] = 0; prv[i] = 0;
      end
      for (int q = 0; q < 5; q++) begin
         head[q] = EMPTY; tail[q] = EMPTY;
      end
      repeat (5) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      test_directed();
      test_random_phases();
      if (errors == 0 && pending_rsp.size() == 0)
         $display("fixed_timeout_timer_queues_unit verification clean");
      else
         $display("fixed_timeout_timer_queues_unit verification failed");
      $finish;
   end

   initial begin
      #4000000;
      $display("fixed_timeout_timer_queues_unit verification failed");
      $finish;
   end
endmodule
